[rtl/core/mte_pkg.sv]
// ----------------------------------------------------------------------------
// mte_pkg
// Shared types, constants and the microcode ROM of the MIDI track encoder.
// ----------------------------------------------------------------------------
package mte_pkg;

  // Tick arithmetic and variable-length quantity layout
  localparam int TICK_BITS  = 28;
  localparam int GRP_W      = 7;
  localparam int VLQ_GROUPS = (TICK_BITS + GRP_W - 1) / GRP_W;
  localparam int VLQ_W      = VLQ_GROUPS * GRP_W;
  localparam int VLQ_IDX_W  = $clog2(VLQ_GROUPS);

  // Input word layout (tdata), lowest bit first
  localparam int TICK_F_W  = 28;
  localparam int VAL_F_W   = 9;
  localparam int TICK_LSB  = 0;
  localparam int ON_LSB    = TICK_LSB + TICK_F_W;
  localparam int PITCH_LSB = ON_LSB + 1;
  localparam int VEL_LSB   = PITCH_LSB + VAL_F_W;
  localparam int BPM_LSB   = VEL_LSB + VAL_F_W;
  localparam int IN_DATA_W = BPM_LSB + VAL_F_W;

  // Event kinds carried in tuser
  localparam logic [1:0] MODE_NOTE  = 2'd0;
  localparam logic [1:0] MODE_TEMPO = 2'd1;
  localparam logic [1:0] MODE_END   = 2'd2;

  // Byte constants of the track format
  localparam logic [7:0] BYTE_ZERO   = 8'h00;
  localparam logic [7:0] BYTE_META   = 8'hFF;
  localparam logic [7:0] META_TEMPO  = 8'h51;
  localparam logic [7:0] TEMPO_LEN   = 8'h03;
  localparam logic [7:0] META_EOT    = 8'h2F;
  localparam logic [3:0] ST_NOTE_ON  = 4'h9;
  localparam logic [3:0] ST_NOTE_OFF = 4'h8;
  localparam logic [7:0] VLQ_CONT    = 8'h80;

  // Tempo division
  localparam int          DIV_BITS      = 26;
  localparam int          US_W          = 24;
  localparam int          BPM_W         = 9;
  localparam logic [25:0] US_PER_MINUTE = 26'd60000000;
  localparam logic [8:0]  BPM_MIN       = 9'd20;
  localparam logic [8:0]  BPM_MAX       = 9'd300;
  localparam logic signed [8:0] VAL7_MAX = 9'sd127;

  // Microcode
  localparam int PC_W = 5;
  typedef logic [PC_W-1:0] pc_t;

  localparam pc_t PC_IDLE  = 5'd0;
  localparam pc_t PC_NOTE  = 5'd1;
  localparam pc_t PC_TEMPO = 5'd6;
  localparam pc_t PC_END   = 5'd14;
  localparam pc_t PC_LAST  = 5'd17;

  typedef enum logic [2:0] {
    SRC_CONST, SRC_VLQ, SRC_STATUS, SRC_PITCH,
    SRC_VEL, SRC_US_HI, SRC_US_MID, SRC_US_LO
  } src_t;

  typedef enum logic [2:0] {
    NX_NEXT, NX_JUMP, NX_VLQ, NX_WAIT_DIV, NX_DISPATCH
  } next_t;

  typedef struct packed {
    logic       emit;
    logic       last;
    src_t       src;
    logic [7:0] lit;
    logic       load_delta;
    logic       clear_tick;
    logic       start_div;
    next_t      nx;
    pc_t        target;
  } uword_t;

  typedef struct packed {
    logic       in_valid;
    logic [1:0] mode;
    logic       out_free;
    logic       vlq_more;
    logic       div_done;
  } seq_stat_t;

  typedef struct packed {
    logic   in_take;
    logic   fire;
    uword_t uw;
  } seq_ctrl_t;

  function automatic uword_t uw(logic emit, logic last, src_t src, logic [7:0] lit,
                                logic ld, logic clr, logic div, next_t nx, pc_t tgt);
    uword_t w;
    w.emit       = emit;
    w.last       = last;
    w.src        = src;
    w.lit        = lit;
    w.load_delta = ld;
    w.clear_tick = clr;
    w.start_div  = div;
    w.nx         = nx;
    w.target     = tgt;
    return w;
  endfunction

  // Program: note, tempo and end-of-track runs
  function automatic uword_t ucode(pc_t pc);
    uword_t w;
    case (pc)
      5'd0:  w = uw(1'b0, 1'b0, SRC_CONST,  BYTE_ZERO,  1'b0, 1'b0, 1'b0, NX_DISPATCH, PC_IDLE);
      5'd1:  w = uw(1'b0, 1'b0, SRC_CONST,  BYTE_ZERO,  1'b1, 1'b0, 1'b0, NX_NEXT,     PC_IDLE);
      5'd2:  w = uw(1'b1, 1'b0, SRC_VLQ,    BYTE_ZERO,  1'b0, 1'b0, 1'b0, NX_VLQ,      PC_IDLE);
      5'd3:  w = uw(1'b1, 1'b0, SRC_STATUS, BYTE_ZERO,  1'b0, 1'b0, 1'b0, NX_NEXT,     PC_IDLE);
      5'd4:  w = uw(1'b1, 1'b0, SRC_PITCH,  BYTE_ZERO,  1'b0, 1'b0, 1'b0, NX_NEXT,     PC_IDLE);
      5'd5:  w = uw(1'b1, 1'b1, SRC_VEL,    BYTE_ZERO,  1'b0, 1'b0, 1'b0, NX_JUMP,     PC_IDLE);
      5'd6:  w = uw(1'b1, 1'b0, SRC_CONST,  BYTE_ZERO,  1'b0, 1'b0, 1'b1, NX_NEXT,     PC_IDLE);
      5'd7:  w = uw(1'b1, 1'b0, SRC_CONST,  BYTE_META,  1'b0, 1'b0, 1'b0, NX_NEXT,     PC_IDLE);
      5'd8:  w = uw(1'b1, 1'b0, SRC_CONST,  META_TEMPO, 1'b0, 1'b0, 1'b0, NX_NEXT,     PC_IDLE);
      5'd9:  w = uw(1'b1, 1'b0, SRC_CONST,  TEMPO_LEN,  1'b0, 1'b0, 1'b0, NX_NEXT,     PC_IDLE);
      5'd10: w = uw(1'b0, 1'b0, SRC_CONST,  BYTE_ZERO,  1'b0, 1'b0, 1'b0, NX_WAIT_DIV, PC_IDLE);
      5'd11: w = uw(1'b1, 1'b0, SRC_US_HI,  BYTE_ZERO,  1'b0, 1'b0, 1'b0, NX_NEXT,     PC_IDLE);
      5'd12: w = uw(1'b1, 1'b0, SRC_US_MID, BYTE_ZERO,  1'b0, 1'b0, 1'b0, NX_NEXT,     PC_IDLE);
      5'd13: w = uw(1'b1, 1'b1, SRC_US_LO,  BYTE_ZERO,  1'b0, 1'b0, 1'b0, NX_JUMP,     PC_IDLE);
      5'd14: w = uw(1'b1, 1'b0, SRC_CONST,  BYTE_ZERO,  1'b0, 1'b1, 1'b0, NX_NEXT,     PC_IDLE);
      5'd15: w = uw(1'b1, 1'b0, SRC_CONST,  BYTE_META,  1'b0, 1'b0, 1'b0, NX_NEXT,     PC_IDLE);
      5'd16: w = uw(1'b1, 1'b0, SRC_CONST,  META_EOT,   1'b0, 1'b0, 1'b0, NX_NEXT,     PC_IDLE);
      5'd17: w = uw(1'b1, 1'b1, SRC_CONST,  BYTE_ZERO,  1'b0, 1'b0, 1'b0, NX_JUMP,     PC_IDLE);
      default: w = uw(1'b0, 1'b0, SRC_CONST, BYTE_ZERO, 1'b0, 1'b0, 1'b0, NX_JUMP,     PC_IDLE);
    endcase
    return w;
  endfunction

  function automatic logic [6:0] clamp7(logic signed [8:0] v);
    logic [6:0] r;
    if (v < 9'sd0) begin
      r = 7'd0;
    end else if (v > VAL7_MAX) begin
      r = 7'd127;
    end else begin
      r = v[6:0];
    end
    return r;
  endfunction

  function automatic logic [8:0] clamp_bpm(logic [8:0] b);
    logic [8:0] r;
    if (b < BPM_MIN) begin
      r = BPM_MIN;
    end else if (b > BPM_MAX) begin
      r = BPM_MAX;
    end else begin
      r = b;
    end
    return r;
  endfunction

endpackage

[rtl/core/mte_div.sv]
// ----------------------------------------------------------------------------
// mte_div
// Restoring divider: microseconds per quarter note from a clamped tempo,
// one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mte_div (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [mte_pkg::BPM_W-1:0] divisor,
  output logic                    busy,
  output logic [mte_pkg::US_W-1:0] quotient
);
  import mte_pkg::*;

  localparam int CNT_W = $clog2(DIV_BITS);

  logic [DIV_BITS-1:0] acc;
  logic [BPM_W-1:0]    rem;
  logic [BPM_W-1:0]    dvsr;
  logic [CNT_W-1:0]    count;
  logic [BPM_W:0]      trial;
  logic                fits;

  assign trial    = {rem, acc[DIV_BITS-1]};
  assign fits     = trial >= {1'b0, dvsr};
  assign quotient = acc[US_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
      acc   <= '0;
    end else if (start && !busy) begin
      busy  <= 1'b1;
      count <= CNT_W'(DIV_BITS - 1);
      acc   <= US_PER_MINUTE;
      rem   <= '0;
      dvsr  <= divisor;
    end else if (busy) begin
      // shift in the next dividend bit, subtract where it fits
      if (fits) begin
        rem <= BPM_W'(trial - {1'b0, dvsr});
      end else begin
        rem <= trial[BPM_W-1:0];
      end
      acc <= {acc[DIV_BITS-2:0], fits};
      if (count == '0) begin
        busy <= 1'b0;
      end else begin
        count <= count - 1'b1;
      end
    end
  end

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("divider did not start");

  a_finish: assert property (@(posedge clk) disable iff (rst)
    busy && count == '0 |=> !busy)
    else $error("divider ran past its last bit");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !busy && !start |=> $stable(acc))
    else $error("quotient changed while idle");

endmodule

[rtl/core/mte_seq.sv]
// ----------------------------------------------------------------------------
// mte_seq
// Microcode sequencer: step counter over the ROM, with dispatch on event
// kind, self-loops and jumps back to idle.
// ----------------------------------------------------------------------------
module mte_seq (
  input  logic                clk,
  input  logic                rst,
  input  mte_pkg::seq_stat_t  stat,
  output mte_pkg::seq_ctrl_t  ctrl
);
  import mte_pkg::*;

  pc_t    pc;
  pc_t    pc_next;
  uword_t w;
  logic   fire;

  function automatic pc_t entry_pc(logic [1:0] mode);
    pc_t p;
    case (mode)
      MODE_NOTE:  p = PC_NOTE;
      MODE_TEMPO: p = PC_TEMPO;
      MODE_END:   p = PC_END;
      default:    p = PC_IDLE;
    endcase
    return p;
  endfunction

  always_comb begin
    w = ucode(pc);
    case (w.nx)
      NX_WAIT_DIV: fire = stat.div_done;
      NX_DISPATCH: fire = stat.in_valid;
      default:     fire = !w.emit || stat.out_free;
    endcase
  end

  always_comb begin
    pc_next = pc;
    if (fire) begin
      case (w.nx)
        NX_NEXT:     pc_next = pc + 1'b1;
        NX_JUMP:     pc_next = w.target;
        NX_VLQ:      pc_next = stat.vlq_more ? pc : pc + 1'b1;
        NX_WAIT_DIV: pc_next = pc + 1'b1;
        NX_DISPATCH: pc_next = entry_pc(stat.mode);
        default:     pc_next = PC_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= PC_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

  assign ctrl.in_take = (w.nx == NX_DISPATCH);
  assign ctrl.fire    = fire;
  assign ctrl.uw      = w;

  a_pc_range: assert property (@(posedge clk) disable iff (rst)
    pc <= PC_LAST)
    else $error("step counter left the program");

  a_vlq_loop: assert property (@(posedge clk) disable iff (rst)
    fire && w.nx == NX_VLQ && stat.vlq_more |=> pc == $past(pc))
    else $error("delta loop exited early");

  a_note_entry: assert property (@(posedge clk) disable iff (rst)
    ctrl.in_take && stat.in_valid && stat.mode == MODE_NOTE |=> pc == PC_NOTE)
    else $error("note event dispatched to wrong step");

endmodule

[rtl/core/midi_track_event_encoder.sv]
// ----------------------------------------------------------------------------
// midi_track_event_encoder
// Turns one track event per input word into Standard MIDI File track bytes.
// ----------------------------------------------------------------------------
// Each input word is one event, its kind on s_tuser. A note event yields the
// tick gap since the previous note as a big-endian variable-length quantity
// (one to four bytes, 0x80 on all but the last), then status (0x90/0x80 with
// the configured channel), pitch and velocity, both clamped to 0..127 and
// velocity zero for note off. A tempo event yields 00 FF 51 03 and the 24-bit
// microseconds per quarter note, 60000000 / bpm with bpm clamped to 20..300.
// An end event yields 00 FF 2F 00 and resets the tick reference. Kind 3 is
// taken and dropped. m_tlast marks the final byte of each event. Bytes leave
// through a single output register, one per cycle while m_tready is high.
// Timing: a microcode step counter runs one step per cycle, holding while it
// waits on the output register or the divider, and takes input only in its
// idle step, so events are handled one at a time. A note passes an accept
// step and a step that forms the gap, then emits its bytes in turn. A tempo
// event waits on the restoring divider for its microsecond bytes. Output
// stalls lengthen an event, except stalls on the tempo header bytes, which
// overlap the divide. The channel register may be written at any time while
// no event is in progress; cfg_ready is always high.
// ----------------------------------------------------------------------------
module midi_track_event_encoder (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // event_tick[27:0], note_on[28], pitch[37:29], velocity[46:38],
  // beats_per_minute[55:47]
  input  logic [mte_pkg::IN_DATA_W-1:0] s_tdata,
  // mode[1:0]
  input  logic [1:0]                    s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // out_byte[7:0]
  output logic [7:0]                    m_tdata,
  output logic                          m_tlast,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [3:0]                    cfg_data
);
  import mte_pkg::*;

  // Event fields, held while the program runs
  logic [TICK_BITS-1:0] tick;
  logic                 note_on;
  logic [6:0]           pitch7;
  logic [6:0]           vel7;
  logic [BPM_W-1:0]     bpm;

  // Track state and configuration
  logic [TICK_BITS-1:0] prev_tick;
  logic [3:0]           channel;

  // Gap and its byte groups
  logic [TICK_BITS-1:0] delta;
  logic [TICK_BITS-1:0] delta_next;
  logic [VLQ_W-1:0]     dpad_next;
  logic [VLQ_W-1:0]     dpad;
  logic [VLQ_IDX_W-1:0] gidx;
  logic [VLQ_IDX_W-1:0] gidx_next;

  logic                 div_busy;
  logic [US_W-1:0]      us;

  seq_stat_t            stat;
  seq_ctrl_t            ctrl;
  logic                 accept;
  logic                 out_free;
  logic [7:0]           byte_sel;

  assign cfg_ready = 1'b1;
  assign s_tready  = ctrl.in_take;
  assign accept    = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;

  assign stat.in_valid = s_tvalid;
  assign stat.mode     = s_tuser;
  assign stat.out_free = out_free;
  assign stat.vlq_more = (gidx != '0);
  assign stat.div_done = !div_busy;

  mte_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctrl (ctrl)
  );

  mte_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (ctrl.fire && ctrl.uw.start_div),
    .divisor  (bpm),
    .busy     (div_busy),
    .quotient (us)
  );

  // Saturating gap; find the highest nonzero 7-bit group to start from
  always_comb begin
    delta_next = (tick >= prev_tick) ? tick - prev_tick : '0;
    dpad_next  = VLQ_W'(delta_next);
    gidx_next  = '0;
    for (int i = 1; i < VLQ_GROUPS; i++) begin
      if (dpad_next[i*GRP_W +: GRP_W] != '0) begin
        gidx_next = VLQ_IDX_W'(i);
      end
    end
  end

  assign dpad = VLQ_W'(delta);

  // Byte source selection
  always_comb begin
    case (ctrl.uw.src)
      SRC_CONST:  byte_sel = ctrl.uw.lit;
      SRC_VLQ:    byte_sel = ((gidx != '0) ? VLQ_CONT : BYTE_ZERO)
                             | {1'b0, dpad[gidx*GRP_W +: GRP_W]};
      SRC_STATUS: byte_sel = {note_on ? ST_NOTE_ON : ST_NOTE_OFF, channel};
      SRC_PITCH:  byte_sel = {1'b0, pitch7};
      SRC_VEL:    byte_sel = {1'b0, vel7};
      SRC_US_HI:  byte_sel = us[23:16];
      SRC_US_MID: byte_sel = us[15:8];
      SRC_US_LO:  byte_sel = us[7:0];
      default:    byte_sel = ctrl.uw.lit;
    endcase
  end

  // Capture the event word; clamp on the way in
  always_ff @(posedge clk) begin
    if (accept) begin
      tick    <= s_tdata[TICK_LSB +: TICK_BITS];
      note_on <= s_tdata[ON_LSB];
      pitch7  <= clamp7(s_tdata[PITCH_LSB +: VAL_F_W]);
      vel7    <= s_tdata[ON_LSB] ? clamp7(s_tdata[VEL_LSB +: VAL_F_W]) : 7'd0;
      bpm     <= clamp_bpm(s_tdata[BPM_LSB +: VAL_F_W]);
    end
    if (ctrl.fire && ctrl.uw.load_delta) begin
      delta <= delta_next;
    end
  end

  // Tick reference, channel, group index and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_tick <= '0;
      channel   <= '0;
      gidx      <= '0;
      m_tvalid  <= 1'b0;
      m_tlast   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        channel <= cfg_data;
      end
      if (ctrl.fire && ctrl.uw.load_delta) begin
        // a backward tick still becomes the new reference
        prev_tick <= tick;
        gidx      <= gidx_next;
      end else if (ctrl.fire && ctrl.uw.clear_tick) begin
        prev_tick <= '0;
      end else if (ctrl.fire && ctrl.uw.nx == NX_VLQ && gidx != '0) begin
        gidx <= gidx - 1'b1;
      end
      if (ctrl.fire && ctrl.uw.emit) begin
        m_tvalid <= 1'b1;
        m_tlast  <= ctrl.uw.last;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.fire && ctrl.uw.emit) begin
      m_tdata <= byte_sel;
    end
  end

  a_idle_groups: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> gidx == '0)
    else $error("idle with delta groups still pending");

  a_div_free: assert property (@(posedge clk) disable iff (rst)
    ctrl.fire && ctrl.uw.start_div |-> !div_busy)
    else $error("tempo division started while busy");

  a_last_out: assert property (@(posedge clk) disable iff (rst)
    ctrl.fire && ctrl.uw.emit && ctrl.uw.last |=> m_tvalid && m_tlast)
    else $error("final byte of event not flagged");

endmodule

[dv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the MIDI track event encoder.
// ----------------------------------------------------------------------------
// Feed note, tempo, end-of-track and dropped event words into the encoder and
// check every output byte and its tlast flag against a byte-level encoder
// kept in the bench. A short table of hand-picked events comes first. Some
// rows carry the exact bytes they must produce; the rest go through the
// bench encoder. Random phases follow, each under its own channel setting
// and its own mix of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module testbench;
  import mte_pkg::*;

  // Kind 3 is taken by the block and dropped
  localparam logic [1:0] MODE_DROPPED = 2'd3;
  localparam int unsigned US_PER_MIN = 60000000;
  localparam int WATCHDOG_LIMIT = 2000;
  // Longest run of the block with no byte leaving: tempo divide plus margin
  localparam int SETTLE_CYCLES = 40;
  localparam int PHASE_EVENTS = 20;
  localparam int DRAIN_EVERY = 15;

  typedef struct packed {
    logic [1:0]        mode;
    logic [27:0]       tick;
    logic              note_on;
    logic signed [8:0] pitch;
    logic signed [8:0] velocity;
    logic [8:0]        bpm;
  } track_ev_t;

  typedef struct packed {
    logic [7:0] value;
    logic       is_last;
  } track_byte_t;

  typedef struct packed {
    track_ev_t   ev;
    int          typed_n;   // -1: use the bench encoder
    logic [55:0] typed;     // first byte in the highest of typed_n bytes
  } table_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [IN_DATA_W-1:0] s_tdata = '0;
  logic [1:0]           s_tuser = MODE_NOTE;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [7:0]           m_tdata;
  logic                 m_tlast;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [3:0]           cfg_data = '0;

  // Bench copy of the encoder state
  logic [27:0]   last_note_tick = '0;
  logic [3:0]    channel_reg = '0;

  track_byte_t   track_bytes_due[$];
  table_row_t    directed_rows[$];
  track_byte_t   due;
  int            mismatch_count = 0;
  int            quiet_cycles = 0;
  int            send_idle_pct = 0;
  int            recv_stall_pct = 0;

  midi_track_event_encoder uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [7:0] limit_to_7bit(logic signed [8:0] v);
    logic [7:0] r;
    if (v < 9'sd0) begin
      r = 8'd0;
    end else if (v > 9'sd127) begin
      r = 8'd127;
    end else begin
      r = {1'b0, v[6:0]};
    end
    return r;
  endfunction

  // Add one byte at the tail of a byte list
  function automatic void append_byte(ref track_byte_t q[$], input logic [7:0] v,
                                      input logic l);
    track_byte_t b;
    b.value   = v;
    b.is_last = l;
    q.insert(q.size(), b);
  endfunction

  // Produce the track bytes of one event; a note advances the tick reference and an end event clears it
  function automatic void encode_event(input track_ev_t ev, ref track_byte_t bytes[$]);
    logic [7:0]  groups[4];
    logic [27:0] delta;
    logic [8:0]  bpm_c;
    int unsigned us;
    int          k;
    bytes.delete();
    case (ev.mode)
      MODE_NOTE: begin
        delta = (ev.tick >= last_note_tick) ? ev.tick - last_note_tick : '0;
        groups[0] = {1'b0, delta[6:0]};
        k = 1;
        delta = delta >> 7;
        while (delta != 0) begin
          groups[k] = {1'b0, delta[6:0]} | VLQ_CONT;
          k++;
          delta = delta >> 7;
        end
        for (int i = k - 1; i >= 0; i--) append_byte(bytes, groups[i], 1'b0);
        append_byte(bytes, {ev.note_on ? ST_NOTE_ON : ST_NOTE_OFF, channel_reg}, 1'b0);
        append_byte(bytes, limit_to_7bit(ev.pitch), 1'b0);
        append_byte(bytes, ev.note_on ? limit_to_7bit(ev.velocity) : 8'd0, 1'b0);
        last_note_tick = ev.tick;
      end
      MODE_TEMPO: begin
        bpm_c = ev.bpm < 9'd20 ? 9'd20 : (ev.bpm > 9'd300 ? 9'd300 : ev.bpm);
        us = US_PER_MIN / bpm_c;
        append_byte(bytes, BYTE_ZERO, 1'b0);
        append_byte(bytes, BYTE_META, 1'b0);
        append_byte(bytes, META_TEMPO, 1'b0);
        append_byte(bytes, TEMPO_LEN, 1'b0);
        append_byte(bytes, us[23:16], 1'b0);
        append_byte(bytes, us[15:8], 1'b0);
        append_byte(bytes, us[7:0], 1'b0);
      end
      MODE_END: begin
        append_byte(bytes, BYTE_ZERO, 1'b0);
        append_byte(bytes, BYTE_META, 1'b0);
        append_byte(bytes, META_EOT, 1'b0);
        append_byte(bytes, BYTE_ZERO, 1'b0);
        last_note_tick = '0;
      end
      default: ;
    endcase
    if (bytes.size() != 0) bytes[bytes.size() - 1].is_last = 1'b1;
  endfunction

  function automatic void add_row(logic [1:0] mode, logic [27:0] tick, logic on,
                                  logic signed [8:0] pitch, logic signed [8:0] vel,
                                  logic [8:0] bpm, int n, logic [55:0] bytes);
    table_row_t r;
    r.ev = '{mode, tick, on, pitch, vel, bpm};
    r.typed_n = n;
    r.typed = bytes;
    directed_rows.insert(directed_rows.size(), r);
  endfunction

  // Random event: mostly forward ticks with gaps of every VLQ length
  function automatic track_ev_t random_event();
    track_ev_t   ev;
    logic [28:0] sum;
    logic [27:0] gap;
    int          pick;
    ev.mode = MODE_NOTE;
    pick = $urandom_range(99);
    if (pick < 10) ev.mode = MODE_TEMPO;
    else if (pick < 18) ev.mode = MODE_END;
    else if (pick < 25) ev.mode = MODE_DROPPED;
    case ($urandom_range(9))
      0, 1, 2: gap = 28'($urandom_range(127));
      3, 4:    gap = 28'($urandom_range(16383, 128));
      5:       gap = 28'($urandom_range(2097151, 16384));
      6:       gap = 28'($urandom_range(268435455, 2097152));
      7:       gap = '0;
      default: gap = 28'($urandom_range(1023));
    endcase
    sum = {1'b0, last_note_tick} + {1'b0, gap};
    ev.tick = sum[28] ? 28'($urandom) : sum[27:0];
    pick = $urandom_range(19);
    if (pick == 0) ev.tick = 28'($urandom);
    else if (pick == 1 && last_note_tick != 0) ev.tick = 28'($urandom_range(last_note_tick - 1));
    ev.note_on = 1'($urandom);
    ev.pitch = ($urandom_range(3) == 0) ? 9'($urandom) : 9'($urandom_range(127));
    ev.velocity = ($urandom_range(3) == 0) ? 9'($urandom) : 9'($urandom_range(127));
    ev.bpm = ($urandom_range(2) == 0) ? 9'($urandom) : 9'($urandom_range(300, 20));
    return ev;
  endfunction

  // Present one event word and predict its bytes once it is taken
  task automatic send_event(input track_ev_t ev, input int typed_n, input logic [55:0] typed);
    track_byte_t bytes[$];
    if ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= ev.mode;
    s_tdata  <= {ev.bpm, ev.velocity, ev.pitch, ev.note_on, ev.tick};
    do @(posedge clk); while (!s_tready);
    encode_event(ev, bytes);
    if (typed_n >= 0) begin
      bytes.delete();
      for (int i = 0; i < typed_n; i++) begin
        append_byte(bytes, 8'(typed >> (8 * (typed_n - 1 - i))), i == typed_n - 1);
      end
    end
    foreach (bytes[i]) track_bytes_due.insert(track_bytes_due.size(), bytes[i]);
  endtask

  // Hold input low until every predicted byte has left
  task automatic drain_track();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (track_bytes_due.size() != 0) @(posedge clk);
  endtask

  // Write the channel only while the encoder is idle
  task automatic write_channel(input logic [3:0] ch);
    drain_track();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= ch;
    do @(posedge clk); while (!cfg_ready);
    channel_reg = ch;
    cfg_valid <= 1'b0;
  endtask

  // Receiver stalls
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Compare each output word with the oldest predicted byte
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (track_bytes_due.size() == 0) begin
        $display("%0t: unexpected byte: expected none, actual %h last %b",
                 $time, m_tdata, m_tlast);
        mismatch_count++;
      end else begin
        due = track_bytes_due.pop_front();
        if (m_tdata !== due.value) begin
          $display("%0t: out_byte expected %h, actual %h", $time, due.value, m_tdata);
          mismatch_count++;
        end
        if (m_tlast !== due.is_last) begin
          $display("%0t: last_byte expected %b, actual %b", $time, due.is_last, m_tlast);
          mismatch_count++;
        end
      end
    end
  end

  // Stop the run if no word moves on any channel for too long
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired", $time);
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    int sent;
    track_ev_t ev;
    int phase_chan[4];
    int phase_send[4];
    int phase_recv[4];

    phase_chan = '{15, 0, $urandom_range(14, 1), 9};
    phase_send = '{0, 52, 0, 36};
    phase_recv = '{0, 0, 52, 36};

    // Rows with typed bytes assume channel 0 from reset
    add_row(MODE_NOTE,    28'd0,         1'b1, 9'sd60,   9'sd100,  9'd0,   4, 56'h00903C64);
    add_row(MODE_TEMPO,   28'hFFFFFFF,   1'b1, -9'sd256, 9'sd255,  9'd0,   7, 56'h00FF51032DC6C0);
    add_row(MODE_TEMPO,   28'd0,         1'b0, 9'sd0,    9'sd0,    9'd511, 7, 56'h00FF5103030D40);
    add_row(MODE_TEMPO,   28'd0,         1'b0, 9'sd0,    9'sd0,    9'd120, 7, 56'h00FF510307A120);
    add_row(MODE_NOTE,    28'hFFFFFFF,   1'b1, 9'sd255,  -9'sd256, 9'd0,   7, 56'hFFFFFF7F907F00);
    // Tick going backwards: gap saturates to zero; note off forces velocity 0
    add_row(MODE_NOTE,    28'hFFFFFF0,   1'b0, -9'sd256, 9'sd255,  9'd511, 4, 56'h00800000);
    add_row(MODE_DROPPED, 28'h5A5A5A5,   1'b1, 9'sd77,   9'sd77,   9'd77,  0, 56'h0);
    add_row(MODE_END,     28'hFFFFFFF,   1'b1, 9'sd255,  9'sd255,  9'd511, 4, 56'h00FF2F00);
    add_row(MODE_NOTE,    28'd127,       1'b1, 9'sd127,  9'sd127,  9'd0,   4, 56'h7F907F7F);
    add_row(MODE_NOTE,    28'd255,       1'b1, -9'sd1,   9'sd128,  9'd0,   5, 56'h81009000_7F);
    add_row(MODE_NOTE,    28'd255,       1'b0, 9'sd64,   9'sd64,   9'd300, -1, 56'h0);
    add_row(MODE_NOTE,    28'd16638,     1'b1, 9'sd0,    9'sd1,    9'd0,   -1, 56'h0);
    add_row(MODE_NOTE,    28'd33022,     1'b1, 9'sd1,    9'sd0,    9'd0,   -1, 56'h0);
    add_row(MODE_NOTE,    28'd2130173,   1'b0, 9'sd126,  9'sd126,  9'd0,   -1, 56'h0);
    add_row(MODE_NOTE,    28'd4227325,   1'b1, 9'sd128,  -9'sd1,   9'd0,   -1, 56'h0);
    add_row(MODE_TEMPO,   28'd3,         1'b1, 9'sd3,    9'sd3,    9'd19,  -1, 56'h0);
    add_row(MODE_TEMPO,   28'd3,         1'b1, 9'sd3,    9'sd3,    9'd301, -1, 56'h0);
    add_row(MODE_TEMPO,   28'd3,         1'b1, 9'sd3,    9'sd3,    9'd300, -1, 56'h0);
    add_row(MODE_NOTE,    28'd100,       1'b1, 9'sd50,   9'sd90,   9'd0,   -1, 56'h0);
    add_row(MODE_END,     28'd0,         1'b0, 9'sd0,    9'sd0,    9'd0,   -1, 56'h0);
    add_row(MODE_NOTE,    28'd5,         1'b1, 9'sd20,   9'sd30,   9'd0,   -1, 56'h0);

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed table under moderate gaps and stalls on both sides
    send_idle_pct = 36;
    recv_stall_pct = 36;
    foreach (directed_rows[i]) begin
      send_event(directed_rows[i].ev, directed_rows[i].typed_n, directed_rows[i].typed);
    end

    // Random phases, each with its own channel and idling mix
    for (int p = 0; p < 4; p++) begin
      write_channel(4'(phase_chan[p]));
      send_idle_pct = phase_send[p];
      recv_stall_pct = phase_recv[p];
      sent = 0;
      while (sent < PHASE_EVENTS) begin
        ev = random_event();
        send_event(ev, -1, 56'h0);
        if (ev.mode != MODE_DROPPED) begin
          sent++;
          if (sent % DRAIN_EVERY == 0) drain_track();
        end
      end
    end

    drain_track();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && track_bytes_due.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
